### rtl/sifs_pkg.sv
package sifs_pkg;

    localparam int WORD_W   = 32;
    localparam int INSERT_W = 20;
    localparam int OFFSET_W = 4;
    localparam int HALF_W   = 16;

    localparam logic [WORD_W-1:0]   SPV_MAGIC       = 32'h0723_0203;
    localparam logic [HALF_W-1:0]   OP_CAPABILITY   = 16'd17;
    localparam logic [HALF_W-1:0]   OP_MEMORY_MODEL = 16'd14;
    localparam logic [HALF_W-1:0]   OP_ENTRY_POINT  = 16'd15;
    localparam logic [HALF_W-1:0]   OP_EXEC_MODE    = 16'd16;
    localparam logic [HALF_W-1:0]   OP_TYPE_IMAGE   = 16'd25;
    localparam logic [WORD_W-1:0]   CAP_READ_NOFMT  = 32'd28;
    localparam logic [WORD_W-1:0]   CAP_WRITE_NOFMT = 32'd29;
    localparam logic [HALF_W-1:0]   IMAGE_MIN_LEN   = 16'd9;
    localparam logic [OFFSET_W-1:0] FORMAT_OFFSET   = 4'd8;
    localparam logic [OFFSET_W-1:0] OFFSET_MAX      = 4'd15;
    localparam logic [INSERT_W-1:0] INSERT_MAX      = 20'hF_FFFF;
    localparam int                  HEADER_START    = 5;

    typedef logic [WORD_W-1:0]   word_t;
    typedef logic [INSERT_W-1:0] insert_pos_t;

endpackage

### rtl/sifs_in_if.sv
interface sifs_in_if
    import sifs_pkg::*;
;
    logic  valid;
    logic  ready;
    word_t code_word;
    logic  final_word;

    modport source (output valid, output code_word, output final_word, input ready);
    modport sink (input valid, input code_word, input final_word, output ready);
endinterface

### rtl/sifs_out_if.sv
interface sifs_out_if
    import sifs_pkg::*;
;
    logic        valid;
    logic        ready;
    word_t       patched_word;
    logic        end_of_module;
    logic        any_format_cleared;
    logic        add_read_capability;
    logic        add_write_capability;
    insert_pos_t insert_position;

    modport source (
        output valid, output patched_word, output end_of_module,
        output any_format_cleared, output add_read_capability,
        output add_write_capability, output insert_position,
        input ready
    );
    modport sink (
        input valid, input patched_word, input end_of_module,
        input any_format_cleared, input add_read_capability,
        input add_write_capability, input insert_position,
        output ready
    );
endinterface

### rtl/spirv_image_format_stripper_core.sv
// each accepted input beat has its result beat registered and offered in the next cycle
// throughput: one word per cycle, set by the single result register; input is
// taken while a finished result waits as long as the consumer takes it that cycle
// reset: asynchronous active low, walker state returns to the start of a module
// and the result register empties; state also restarts after every final word
module spirv_image_format_stripper_core
    import sifs_pkg::*;
#(
    parameter int POSITION_WIDTH = 20
) (
    input  logic              clk,
    input  logic              rst_n,
    sifs_in_if.sink           in_words,
    sifs_out_if.source        out_words
);

    localparam int PW    = POSITION_WIDTH;
    localparam int SUM_W = ((PW > HALF_W) ? PW : HALF_W) + 1;
    localparam int EXT_W = (PW > INSERT_W) ? PW : INSERT_W;
    localparam logic [PW-1:0] POS_MAX   = '1;
    localparam logic [PW-1:0] POS_START = PW'(HEADER_START);

    // walker state
    logic [PW-1:0]       pos_reg, next_start_reg, cap_end_reg;
    logic                module_valid_reg, walk_stopped_reg, cap_open_reg;
    logic                seen_rd_reg, seen_wr_reg, cleared_reg, cap_pending_reg;
    logic                img_long_reg;
    logic [OFFSET_W-1:0] offset_reg;

    logic [PW-1:0]       pos_next, next_start_next, cap_end_next;
    logic                module_valid_next, walk_stopped_next, cap_open_next;
    logic                seen_rd_next, seen_wr_next, cleared_next, cap_pending_next;
    logic                img_long_next;
    logic [OFFSET_W-1:0] offset_next;

    // result register
    logic        out_valid_reg;
    word_t       patched_reg;
    logic        eom_reg, any_clr_reg, add_rd_reg, add_wr_reg;
    insert_pos_t insert_reg;

    logic               accept, last, walk, header, clear;
    word_t              w, res_word;
    logic [HALF_W-1:0]  op, wc;
    logic [SUM_W-1:0]   sum;
    logic [PW-1:0]      sum_sat;
    logic [OFFSET_W-1:0] offset_inc;
    logic [EXT_W-1:0]   cap_end_ext;
    insert_pos_t        insert_sat;

    assign in_words.ready = !out_valid_reg || out_words.ready;
    assign accept         = in_words.valid && in_words.ready;
    assign w              = in_words.code_word;
    assign last           = in_words.final_word;

    assign op  = w[HALF_W-1:0];
    assign wc  = w[WORD_W-1:HALF_W];
    assign sum = SUM_W'(pos_reg) + SUM_W'(wc);
    assign sum_sat = (sum > SUM_W'(POS_MAX)) ? POS_MAX : sum[PW-1:0];

    assign walk = module_valid_reg && !walk_stopped_reg && (pos_reg != '0) &&
                  (pos_reg >= POS_START) && (pos_reg != POS_MAX);
    assign header     = walk && (pos_reg == next_start_reg);
    assign offset_inc = (offset_reg != OFFSET_MAX) ? offset_reg + 1'b1 : offset_reg;
    assign clear      = walk && !header && img_long_reg &&
                        (offset_inc == FORMAT_OFFSET) && (w != '0);
    assign res_word   = clear ? '0 : w;

    always_comb
    begin
        pos_next          = (pos_reg != POS_MAX) ? pos_reg + 1'b1 : pos_reg;
        module_valid_next = module_valid_reg;
        walk_stopped_next = walk_stopped_reg;
        next_start_next   = next_start_reg;
        cap_end_next      = cap_end_reg;
        cap_open_next     = cap_open_reg;
        seen_rd_next      = seen_rd_reg || (cap_pending_reg && (w == CAP_READ_NOFMT));
        seen_wr_next      = seen_wr_reg || (cap_pending_reg && (w == CAP_WRITE_NOFMT));
        cleared_next      = cleared_reg || clear;
        cap_pending_next  = 1'b0;
        img_long_next     = img_long_reg;
        offset_next       = offset_reg;

        if (pos_reg == '0)
        begin
            module_valid_next = (w == SPV_MAGIC);
        end
        else if (header)
        begin
            if (wc == '0)
            begin
                walk_stopped_next = 1'b1;
                cap_open_next     = 1'b0;
            end
            else
            begin
                if (cap_open_reg)
                begin
                    if (op == OP_CAPABILITY)
                    begin
                        cap_pending_next = 1'b1;
                        cap_end_next     = sum_sat;
                    end
                    else if ((op == OP_MEMORY_MODEL) || (op == OP_ENTRY_POINT) ||
                             (op == OP_EXEC_MODE) || (op == OP_TYPE_IMAGE))
                    begin
                        cap_open_next = 1'b0;
                    end
                end
                next_start_next = sum_sat;
                img_long_next   = (op == OP_TYPE_IMAGE) && (wc >= IMAGE_MIN_LEN);
                offset_next     = '0;
            end
        end
        else if (walk)
        begin
            offset_next = offset_inc;
        end
    end

    assign cap_end_ext = EXT_W'(cap_end_next);
    assign insert_sat  = (cap_end_ext > EXT_W'(INSERT_MAX)) ? INSERT_MAX
                                                            : cap_end_ext[INSERT_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg          <= '0;
            module_valid_reg <= 1'b0;
            walk_stopped_reg <= 1'b0;
            next_start_reg   <= POS_START;
            cap_end_reg      <= POS_START;
            cap_open_reg     <= 1'b1;
            seen_rd_reg      <= 1'b0;
            seen_wr_reg      <= 1'b0;
            cleared_reg      <= 1'b0;
            cap_pending_reg  <= 1'b0;
            img_long_reg     <= 1'b0;
            offset_reg       <= '0;
        end
        else if (accept)
        begin
            // final word: start over for the next module
            if (last)
            begin
                pos_reg          <= '0;
                module_valid_reg <= 1'b0;
                walk_stopped_reg <= 1'b0;
                next_start_reg   <= POS_START;
                cap_end_reg      <= POS_START;
                cap_open_reg     <= 1'b1;
                seen_rd_reg      <= 1'b0;
                seen_wr_reg      <= 1'b0;
                cleared_reg      <= 1'b0;
                cap_pending_reg  <= 1'b0;
                img_long_reg     <= 1'b0;
                offset_reg       <= '0;
            end
            else
            begin
                pos_reg          <= pos_next;
                module_valid_reg <= module_valid_next;
                walk_stopped_reg <= walk_stopped_next;
                next_start_reg   <= next_start_next;
                cap_end_reg      <= cap_end_next;
                cap_open_reg     <= cap_open_next;
                seen_rd_reg      <= seen_rd_next;
                seen_wr_reg      <= seen_wr_next;
                cleared_reg      <= cleared_next;
                cap_pending_reg  <= cap_pending_next;
                img_long_reg     <= img_long_next;
                offset_reg       <= offset_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_words.ready)
        begin
            out_valid_reg <= in_words.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            patched_reg <= res_word;
            eom_reg     <= last;
            any_clr_reg <= last && cleared_next;
            add_rd_reg  <= last && cleared_next && !seen_rd_next;
            add_wr_reg  <= last && cleared_next && !seen_wr_next;
            insert_reg  <= last ? insert_sat : '0;
        end
    end

    assign out_words.valid                = out_valid_reg;
    assign out_words.patched_word         = patched_reg;
    assign out_words.end_of_module        = eom_reg;
    assign out_words.any_format_cleared   = any_clr_reg;
    assign out_words.add_read_capability  = add_rd_reg;
    assign out_words.add_write_capability = add_wr_reg;
    assign out_words.insert_position      = insert_reg;

endmodule

### rtl/sifs_checker.sv
module sifs_checker
    import sifs_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic        end_of_module,
    input logic        any_format_cleared,
    input logic        add_read_capability,
    input logic        add_write_capability,
    input insert_pos_t insert_position
);

    // a stalled result beat stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result beat dropped while stalled");

    // every accepted word shows up as a result on the next cycle
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("accepted word produced no result");

    // summary fields are quiet on all but the last word
    a_summary_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !end_of_module |-> !any_format_cleared &&
            !add_read_capability && !add_write_capability && (insert_position == '0))
        else $error("summary fields set on a non-final beat");

    // capabilities are requested only when some format was stripped
    a_add_needs_clear: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (add_read_capability || add_write_capability) |->
            any_format_cleared)
        else $error("capability requested without a cleared format");

endmodule

bind spirv_image_format_stripper_core sifs_checker u_sifs_checker (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_words.valid),
    .in_ready             (in_words.ready),
    .out_valid            (out_words.valid),
    .out_ready            (out_words.ready),
    .end_of_module        (out_words.end_of_module),
    .any_format_cleared   (out_words.any_format_cleared),
    .add_read_capability  (out_words.add_read_capability),
    .add_write_capability (out_words.add_write_capability),
    .insert_position      (out_words.insert_position)
);

### test/spirv_image_format_stripper_core_test.sv
module spirv_image_format_stripper_core_test;
    import sifs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned POS_BITS       = 20;
    localparam int unsigned POS_TOP        = (32'd1 << POS_BITS) - 1;
    localparam int unsigned RANDOM_WORDS   = 650;
    localparam int unsigned DRAIN_LIMIT    = 10000;

    typedef struct packed {
        word_t       patched_word;
        logic        end_of_module;
        logic        any_format_cleared;
        logic        add_read_capability;
        logic        add_write_capability;
        insert_pos_t insert_position;
    } strip_result_t;

    logic clk = 1'b0;
    logic rst_n;

    sifs_in_if  in_words ();
    sifs_out_if out_words ();

    spirv_image_format_stripper_core #(
        .POSITION_WIDTH(POS_BITS)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_words (in_words),
        .out_words(out_words)
    );

    always #5 clk = ~clk;

    // walker state of the predictor
    int unsigned   word_pos;
    int unsigned   next_header;
    int unsigned   cap_end_pos;
    logic          magic_ok;
    logic          walk_done;
    logic          cap_open;
    logic          saw_read_cap;
    logic          saw_write_cap;
    logic          format_cleared;
    logic          cap_check_next;
    logic [15:0]   instr_opcode;
    logic [15:0]   instr_length;
    logic [3:0]    instr_offset;

    strip_result_t expected_results[$];
    word_t         module_words[$];

    int unsigned errors;
    int unsigned words_sent;
    int unsigned results_seen;
    int unsigned modules_sent;
    int unsigned modules_stripped;
    int unsigned burst_left;

    function automatic void restart_walker();
        word_pos       = 0;
        next_header    = HEADER_START;
        cap_end_pos    = HEADER_START;
        magic_ok       = 1'b0;
        walk_done      = 1'b0;
        cap_open       = 1'b1;
        saw_read_cap   = 1'b0;
        saw_write_cap  = 1'b0;
        format_cleared = 1'b0;
        cap_check_next = 1'b0;
        instr_opcode   = '0;
        instr_length   = '0;
        instr_offset   = '0;
    endfunction

    function automatic int unsigned sat_pos(int unsigned a, int unsigned b);
        int unsigned s;
        s = a + b;
        return (s > POS_TOP) ? POS_TOP : s;
    endfunction

    function automatic strip_result_t strip_word(word_t w, logic is_last);
        strip_result_t r;
        int unsigned   p;
        logic [15:0]   op;
        logic [15:0]   wc;
        p              = word_pos;
        op             = w[15:0];
        wc             = w[31:16];
        r              = '0;
        r.patched_word = w;

        if (cap_check_next)
        begin
            if (w == CAP_READ_NOFMT)
                saw_read_cap = 1'b1;
            if (w == CAP_WRITE_NOFMT)
                saw_write_cap = 1'b1;
            cap_check_next = 1'b0;
        end

        if (p == 0)
        begin
            magic_ok = (w == SPV_MAGIC);
        end
        else if (magic_ok && !walk_done && p >= HEADER_START && p < POS_TOP)
        begin
            if (p == next_header)
            begin
                if (wc == 16'd0)
                begin
                    walk_done = 1'b1;
                    cap_open  = 1'b0;
                end
                else
                begin
                    if (cap_open)
                    begin
                        if (op == OP_CAPABILITY)
                        begin
                            cap_check_next = 1'b1;
                            cap_end_pos    = sat_pos(p, wc);
                        end
                        else if (op == OP_MEMORY_MODEL || op == OP_ENTRY_POINT ||
                                 op == OP_EXEC_MODE || op == OP_TYPE_IMAGE)
                        begin
                            cap_open = 1'b0;
                        end
                    end
                    next_header  = sat_pos(p, wc);
                    instr_opcode = op;
                    instr_length = wc;
                    instr_offset = '0;
                end
            end
            else
            begin
                if (instr_offset < OFFSET_MAX)
                    instr_offset = instr_offset + 1'b1;
                if (instr_opcode == OP_TYPE_IMAGE && instr_length >= IMAGE_MIN_LEN &&
                    instr_offset == FORMAT_OFFSET && w != '0)
                begin
                    r.patched_word = '0;
                    format_cleared = 1'b1;
                end
            end
        end

        r.end_of_module = is_last;
        if (is_last)
        begin
            r.any_format_cleared   = format_cleared;
            r.add_read_capability  = format_cleared && !saw_read_cap;
            r.add_write_capability = format_cleared && !saw_write_cap;
            r.insert_position      = (cap_end_pos > INSERT_MAX) ? INSERT_MAX
                                                                : cap_end_pos[INSERT_W-1:0];
            restart_walker();
        end
        else
        begin
            word_pos = sat_pos(p, 1);
        end
        return r;
    endfunction

    // one beat on the input side, with bursts and gaps
    task automatic send_word(input word_t w, input logic is_last);
        int unsigned   gap;
        strip_result_t want;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                in_words.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        in_words.valid      <= 1'b1;
        in_words.code_word  <= w;
        in_words.final_word <= is_last;
        @(posedge clk);
        while (!in_words.ready)
            @(posedge clk);
        want = strip_word(w, is_last);
        expected_results.insert(expected_results.size(), want);
        burst_left--;
        words_sent++;
        if (is_last)
        begin
            modules_sent++;
            if (want.any_format_cleared)
                modules_stripped++;
        end
    endtask

    task automatic send_module();
        for (int i = 0; i < module_words.size(); i++)
            send_word(module_words[i], i == module_words.size() - 1);
    endtask

    function automatic void append_word(word_t w);
        module_words.insert(module_words.size(), w);
    endfunction

    function automatic word_t pick_capability();
        case ($urandom_range(0, 3))
            0: return CAP_READ_NOFMT;
            1: return CAP_WRITE_NOFMT;
            2: return $urandom_range(0, 40);
            default: return $urandom();
        endcase
    endfunction

    function automatic void push_instr(logic [15:0] op, int unsigned wc);
        append_word({wc[15:0], op});
        for (int unsigned i = 1; i < wc; i++)
        begin
            if (op == OP_TYPE_IMAGE && i == FORMAT_OFFSET)
            begin
                case ($urandom_range(0, 3))
                    0: append_word('0);
                    1: append_word($urandom_range(1, 40));
                    default: append_word($urandom());
                endcase
            end
            else
            begin
                append_word($urandom());
            end
        end
    endfunction

    // header, capability section, then a few instructions; some get cut short
    function automatic void build_module();
        int unsigned cap_hdr_idx;
        int unsigned wc;
        int unsigned len_pick;
        int unsigned cut;
        logic [15:0] closers[3];
        closers = '{OP_MEMORY_MODEL, OP_ENTRY_POINT, OP_EXEC_MODE};
        module_words.delete();
        if ($urandom_range(0, 9) == 0)
            append_word($urandom());
        else
            append_word(SPV_MAGIC);
        repeat (4) append_word($urandom());

        cap_hdr_idx = 0;
        repeat ($urandom_range(0, 3))
        begin
            wc          = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 2;
            cap_hdr_idx = module_words.size();
            append_word({wc[15:0], OP_CAPABILITY});
            if (wc >= 2)
                append_word(pick_capability());
            if (wc == 3)
                append_word($urandom());
        end
        if ($urandom_range(0, 1) == 1)
            push_instr(closers[$urandom_range(0, 2)], $urandom_range(1, 3));

        repeat ($urandom_range(1, 5))
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3:
                begin
                    len_pick = $urandom_range(0, 7);
                    if (len_pick == 0)
                        wc = 8;
                    else if (len_pick == 1)
                        wc = $urandom_range(17, 20);
                    else
                        wc = $urandom_range(9, 12);
                    push_instr(OP_TYPE_IMAGE, wc);
                end
                4:
                begin
                    append_word({16'd2, OP_CAPABILITY});
                    append_word(pick_capability());
                end
                5: append_word({16'd0, 16'($urandom())});
                6: append_word($urandom());
                default: push_instr(16'($urandom()), $urandom_range(1, 4));
            endcase
        end

        if (cap_hdr_idx != 0 && $urandom_range(0, 9) == 0)
        begin
            // module ends right on a capability header
            while (module_words.size() > cap_hdr_idx + 1)
                void'(module_words.pop_back());
        end
        else if ($urandom_range(0, 6) == 0)
        begin
            cut = $urandom_range(1, module_words.size());
            while (module_words.size() > cut)
                void'(module_words.pop_back());
        end
    endfunction

    task automatic test_bad_magic();
        module_words = '{32'h0723_0202, 32'hFFFF_FFFF};
        send_module();
    endtask

    task automatic test_short_module();
        module_words = '{SPV_MAGIC, 32'h0, 32'hFFFF_FFFF, 32'h0, {16'd9, OP_TYPE_IMAGE}};
        send_module();
    endtask

    task automatic test_format_strip();
        // a count-of-one capability still gets its next word checked
        module_words = '{SPV_MAGIC, 32'h0, 32'h0, 32'h0, 32'h0,
                         {16'd2, OP_CAPABILITY}, CAP_READ_NOFMT,
                         {16'd1, OP_CAPABILITY},
                         {16'd9, OP_TYPE_IMAGE}};
        repeat (7) append_word($urandom());
        append_word(32'hFFFF_FFFF);
        send_module();
    endtask

    task automatic test_capability_at_end();
        module_words = '{SPV_MAGIC, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0,
                         {16'hFFFF, OP_CAPABILITY}};
        send_module();
    endtask

    task automatic test_random_modules();
        int unsigned start;
        start = words_sent;
        while (words_sent - start < RANDOM_WORDS)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                // noise: raw words, sometimes behind a valid magic
                module_words.delete();
                append_word(($urandom_range(0, 1) == 1) ? SPV_MAGIC : $urandom());
                repeat ($urandom_range(0, 11)) append_word($urandom());
            end
            else
            begin
                build_module();
            end
            send_module();
        end
    endtask

    function automatic void compare_field(string field, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
            errors++;
        end
    endfunction

    always @(posedge clk)
    begin : result_check
        strip_result_t want;
        if (rst_n && out_words.valid && out_words.ready)
        begin
            results_seen++;
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result beat, expected none, actual word %h",
                         $time, out_words.patched_word);
                errors++;
            end
            else
            begin
                want = expected_results.pop_front();
                compare_field("patched_word", want.patched_word, out_words.patched_word);
                compare_field("end_of_module", 32'(want.end_of_module),
                              32'(out_words.end_of_module));
                compare_field("any_format_cleared", 32'(want.any_format_cleared),
                              32'(out_words.any_format_cleared));
                compare_field("add_read_capability", 32'(want.add_read_capability),
                              32'(out_words.add_read_capability));
                compare_field("add_write_capability", 32'(want.add_write_capability),
                              32'(out_words.add_write_capability));
                compare_field("insert_position", 32'(want.insert_position),
                              32'(out_words.insert_position));
            end
        end
    end

    // receiver stalls in spans of changing pattern
    initial
    begin : ready_pattern
        int unsigned mode;
        int unsigned span;
        int unsigned tick;
        out_words.ready <= 1'b0;
        tick = 0;
        @(posedge rst_n);
        forever
        begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(20, 120);
            repeat (span)
            begin
                @(posedge clk);
                tick++;
                case (mode)
                    0: out_words.ready <= 1'b1;
                    1: out_words.ready <= 1'($urandom_range(0, 1));
                    2: out_words.ready <= (tick % 4) != 0;
                    default: out_words.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("timeout with %0d results still expected", expected_results.size());
        $display("FAIL spirv_image_format_stripper_core");
        $finish;
    end

    initial
    begin : main_sequence
        int unsigned drain;
        errors              = 0;
        words_sent          = 0;
        results_seen        = 0;
        modules_sent        = 0;
        modules_stripped    = 0;
        burst_left          = 0;
        restart_walker();
        rst_n               = 1'b0;
        in_words.valid      <= 1'b0;
        in_words.code_word  <= '0;
        in_words.final_word <= 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_bad_magic();
        test_short_module();
        test_format_strip();
        test_capability_at_end();
        test_random_modules();

        in_words.valid <= 1'b0;
        drain = 0;
        while (expected_results.size() != 0 && drain < DRAIN_LIMIT)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (5) @(posedge clk);
        if (expected_results.size() != 0)
        begin
            $display("%0t: %0d results never arrived, expected 0 outstanding, actual %0d",
                     $time, expected_results.size(), expected_results.size());
            errors++;
        end

        $display("%0d words in %0d modules sent, %0d result beats checked",
                 words_sent, modules_sent, results_seen);
        $display("%0d modules had an image format stripped, %0d mismatches",
                 modules_stripped, errors);
        if (errors == 0)
            $display("PASS spirv_image_format_stripper_core");
        else
            $display("FAIL spirv_image_format_stripper_core");
        $finish;
    end

endmodule

### files.f
rtl/sifs_pkg.sv
rtl/sifs_in_if.sv
rtl/sifs_out_if.sv
rtl/spirv_image_format_stripper_core.sv
rtl/sifs_checker.sv
test/spirv_image_format_stripper_core_test.sv
